// File: rtl/core/kdf_pkg.sv
// Shared types and constants for the KISS deframer with transmit ring.
// No dependencies; imported by every module of the block except kdf_ram.
`default_nettype none
package kdf_pkg;

	localparam int RING_DEPTH_DEF = 8192;
	localparam int NUM_PARAMS     = 5;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic [7:0] FEND      = 8'hC0;
	localparam logic [7:0] FESC      = 8'hDB;
	localparam logic [7:0] TFEND     = 8'hDC;
	localparam logic [7:0] TFESC     = 8'hDD;
	localparam logic [7:0] IDLE_FLAG = 8'h7E;
	localparam logic [3:0] SEL_MASK  = 4'hF;

	typedef enum logic {
		OP_HOST_BYTE = 1'b0,
		OP_DEQUEUE   = 1'b1
	} opcode_t;

	typedef enum logic [3:0] {
		SEL_DATA        = 4'd0,
		SEL_KEYUP_DELAY = 4'd1,
		SEL_PERSISTENCE = 4'd2,
		SEL_SLOT_PERIOD = 4'd3,
		SEL_TX_TAIL     = 4'd4,
		SEL_DUPLEX_MODE = 4'd5
	} param_sel_t;

	// Index 0 is tx delay, then persistence, slot time, tx tail, full duplex.
	typedef logic [NUM_PARAMS-1:0][7:0] param_bank_t;

	typedef struct packed {
		logic is_deq;
		logic hit;
		logic ring_empty;
		logic store_req;
	} item_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/core/kiss_deframer_with_tx_fifo.sv
// KISS host-link deframer with a transmit byte ring. Each request is a host byte
// (opcode 0), which the KISS decoder takes as a delimiter, an escape, a selector, a
// parameter write or a ring append, or a dequeue (opcode 1), which returns the
// oldest ring byte or 0x7E when the ring is empty. Every request gives exactly one
// result carrying all five parameters. Sustained rate is one request per cycle while
// the output is not stalled. A request passes through the two-entry request queue,
// then the registered ring RAM read, and lands in the output register. The input
// stalls only when the queue holds two requests, which takes a stalled output. The
// ring has no overflow check and needs no clearing pass.
`default_nettype none
module kiss_deframer_with_tx_fifo import kdf_pkg::*; #(
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       opcode,
	input  wire logic [7:0] host_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic            ring_empty,
	output logic            store_request,
	output logic [7:0]      keyup_delay,
	output logic [7:0]      persistence,
	output logic [7:0]      slot_period,
	output logic [7:0]      tx_tail,
	output logic [7:0]      duplex_mode
);

	localparam int AW = $clog2(RING_DEPTH);

	logic          q_full, push, pop, head_valid;
	item_ctrl_t    push_ctrl, head_ctrl;
	param_bank_t   push_params, head_params, params;
	logic [AW-1:0] push_addr, head_addr;
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]    ram_wdata, ram_rdata;

	kdf_front #(.RING_DEPTH(RING_DEPTH)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.host_byte   (host_byte),
		.q_full      (q_full),
		.push        (push),
		.push_ctrl   (push_ctrl),
		.push_params (push_params),
		.push_addr   (push_addr),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata)
	);

	kdf_queue #(.AW(AW)) u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.push_ctrl   (push_ctrl),
		.push_params (push_params),
		.push_addr   (push_addr),
		.full        (q_full),
		.head_valid  (head_valid),
		.head_ctrl   (head_ctrl),
		.head_params (head_params),
		.head_addr   (head_addr),
		.pop         (pop)
	);

	kdf_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_ring (
		.clk   (clk),
		.we    (ram_we && push),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	kdf_back #(.AW(AW)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_ctrl     (head_ctrl),
		.head_params   (head_params),
		.head_addr     (head_addr),
		.pop           (pop),
		.ram_re        (ram_re),
		.ram_raddr     (ram_raddr),
		.ram_rdata     (ram_rdata),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.ring_empty    (ring_empty),
		.store_request (store_request),
		.params        (params)
	);

	assign keyup_delay = params[0];
	assign persistence = params[1];
	assign slot_period = params[2];
	assign tx_tail     = params[3];
	assign duplex_mode = params[4];

endmodule
`default_nettype wire

// File: rtl/core/kdf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module kdf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/kdf_front.sv
// Front end: accepts requests, runs the KISS decoder, owns ring pointers and parameters.
// Depends on kdf_pkg; writes the ring RAM and pushes into kdf_queue.
`default_nettype none
module kdf_front import kdf_pkg::*; #(
	parameter int RING_DEPTH = RING_DEPTH_DEF,
	localparam int AW = $clog2(RING_DEPTH)
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        opcode,
	input  wire logic [7:0]  host_byte,
	input  wire logic        q_full,
	output logic             push,
	output item_ctrl_t       push_ctrl,
	output param_bank_t      push_params,
	output logic [AW-1:0]    push_addr,
	output logic             ram_we,
	output logic [AW-1:0]    ram_waddr,
	output logic [7:0]       ram_wdata
);

	localparam logic [AW-1:0] LAST_PTR = AW'(RING_DEPTH - 1);

	logic [AW-1:0] rd_ptr_q, wr_ptr_q, rd_ptr_d, wr_ptr_d;
	logic          cmd_q, esc_q, cmd_d, esc_d;
	param_sel_t    sel_q, sel_d;
	param_bank_t   params_q, params_d;
	logic          hit, store_req, is_deq;
	logic [7:0]    c_dec;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;
	assign is_deq   = (opcode_t'(opcode) == OP_DEQUEUE);

	always_comb begin
		rd_ptr_d  = rd_ptr_q;
		wr_ptr_d  = wr_ptr_q;
		cmd_d     = cmd_q;
		esc_d     = esc_q;
		sel_d     = sel_q;
		params_d  = params_q;
		hit       = 1'b0;
		store_req = 1'b0;
		ram_we    = 1'b0;
		c_dec     = host_byte;
		if (is_deq) begin
			hit = (rd_ptr_q != wr_ptr_q);
			if (hit) begin
				rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
		end else if (host_byte == FEND) begin
			cmd_d = 1'b1;
		end else if (host_byte == FESC) begin
			esc_d = 1'b1;
		end else begin
			// undo the transpose under an armed escape
			if (esc_q) begin
				if (host_byte == TFEND) begin
					c_dec = FEND;
				end else if (host_byte == TFESC) begin
					c_dec = FESC;
				end
				esc_d = 1'b0;
			end
			if (cmd_q) begin
				sel_d = param_sel_t'(c_dec[3:0] & SEL_MASK);
				cmd_d = 1'b0;
			end else if (sel_q != SEL_DATA) begin
				case (sel_q)
					SEL_KEYUP_DELAY: params_d[0] = c_dec;
					SEL_PERSISTENCE: params_d[1] = c_dec;
					SEL_SLOT_PERIOD: params_d[2] = c_dec;
					SEL_TX_TAIL:     params_d[3] = c_dec;
					SEL_DUPLEX_MODE: params_d[4] = c_dec;
					default: ;
				endcase
				store_req = 1'b1;
				sel_d     = SEL_DATA;
			end else begin
				ram_we   = 1'b1;
				wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
		end
	end

	assign ram_waddr = wr_ptr_q;
	assign ram_wdata = c_dec;

	always_comb begin
		push_ctrl.is_deq     = is_deq;
		push_ctrl.hit        = hit;
		push_ctrl.ring_empty = (rd_ptr_d == wr_ptr_d);
		push_ctrl.store_req  = store_req;
		push_params          = params_d;
		push_addr            = rd_ptr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			cmd_q    <= 1'b0;
			esc_q    <= 1'b0;
			sel_q    <= SEL_DATA;
			params_q <= '0;
		end else if (push) begin
			rd_ptr_q <= rd_ptr_d;
			wr_ptr_q <= wr_ptr_d;
			cmd_q    <= cmd_d;
			esc_q    <= esc_d;
			sel_q    <= sel_d;
			params_q <= params_d;
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/kdf_queue.sv
// Short queue between front and back ends; holds decoded requests in order.
// Depends on kdf_pkg.
`default_nettype none
module kdf_queue import kdf_pkg::*; #(
	parameter int AW = 13
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire item_ctrl_t    push_ctrl,
	input  wire param_bank_t   push_params,
	input  wire logic [AW-1:0] push_addr,
	output logic               full,
	output logic               head_valid,
	output item_ctrl_t         head_ctrl,
	output param_bank_t        head_params,
	output logic [AW-1:0]      head_addr,
	input  wire logic          pop
);

	localparam int QW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	item_ctrl_t    ctrl_q   [QUEUE_DEPTH];
	param_bank_t   params_q [QUEUE_DEPTH];
	logic [AW-1:0] addr_q   [QUEUE_DEPTH];
	logic [QW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;

	assign full        = (count_q == CW'(QUEUE_DEPTH));
	assign head_valid  = (count_q != '0);
	assign head_ctrl   = ctrl_q[rd_q];
	assign head_params = params_q[rd_q];
	assign head_addr   = addr_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ctrl_q[wr_q]   <= push_ctrl;
			params_q[wr_q] <= push_params;
			addr_q[wr_q]   <= push_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/kdf_back.sv
// Back end: reads the ring for dequeues and drives the registered result.
// Depends on kdf_pkg; reads the ring RAM and pops kdf_queue.
`default_nettype none
module kdf_back import kdf_pkg::*; #(
	parameter int AW = 13
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          head_valid,
	input  wire item_ctrl_t    head_ctrl,
	input  wire param_bank_t   head_params,
	input  wire logic [AW-1:0] head_addr,
	output logic               pop,
	output logic               ram_re,
	output logic [AW-1:0]      ram_raddr,
	input  wire logic [7:0]    ram_rdata,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic [7:0]         out_byte,
	output logic               ring_empty,
	output logic               store_request,
	output param_bank_t        params
);

	logic        s1_valid_q;
	item_ctrl_t  ctrl_s1;
	param_bank_t params_s1;
	logic        s1_move;
	logic [7:0]  byte_s1;

	// RAM read data holds while s1 waits, since the read enable only fires on pop.
	assign s1_move   = s1_valid_q && (!out_valid || !out_stall);
	assign pop       = head_valid && (!s1_valid_q || s1_move);
	assign ram_re    = pop && head_ctrl.is_deq && head_ctrl.hit;
	assign ram_raddr = head_addr;

	always_comb begin
		if (!ctrl_s1.is_deq) begin
			byte_s1 = 8'h00;
		end else if (ctrl_s1.hit) begin
			byte_s1 = ram_rdata;
		end else begin
			byte_s1 = IDLE_FLAG;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ctrl_s1   <= head_ctrl;
			params_s1 <= head_params;
		end
		if (s1_move) begin
			out_byte      <= byte_s1;
			ring_empty    <= ctrl_s1.ring_empty;
			store_request <= ctrl_s1.store_req;
			params        <= params_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			if (pop) begin
				s1_valid_q <= 1'b1;
			end else if (s1_move) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_move) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the KISS deframer with its transmit byte ring.
// Depends on kdf_pkg and kiss_deframer_with_tx_fifo; decodes every accepted request
// in a local copy of the block and compares each result field by field.
module tb_top;
	import kdf_pkg::*;

	localparam int QUIET_TAIL     = 400;
	localparam int RANDOM_ITEMS   = 920;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 20;

	typedef struct packed {
		opcode_t    op;
		logic [7:0] data;
	} kiss_req_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        empty;
		logic        store;
		param_bank_t prm;
	} kiss_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       opcode = 1'b0;
	logic [7:0] host_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       ring_empty;
	logic       store_request;
	logic [7:0] keyup_delay;
	logic [7:0] persistence;
	logic [7:0] slot_period;
	logic [7:0] tx_tail;
	logic [7:0] duplex_mode;

	kiss_deframer_with_tx_fifo uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.host_byte(host_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.ring_empty(ring_empty),
		.store_request(store_request),
		.keyup_delay(keyup_delay),
		.persistence(persistence),
		.slot_period(slot_period),
		.tx_tail(tx_tail),
		.duplex_mode(duplex_mode)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	kiss_req_t    host_requests[$];
	kiss_result_t pending_results[$];
	int           n_total;
	int           n_accepted;
	int           n_results;
	int           n_errors;
	int           host_count;

	// decoder copy
	bit [7:0]    ring_copy[RING_DEPTH_DEF];
	int unsigned rd_ptr;
	int unsigned wr_ptr;
	bit          cmd_armed;
	bit          esc_armed;
	logic [3:0]  sel;
	param_bank_t params;

	function automatic int unsigned next_slot(int unsigned p);
		return (p == RING_DEPTH_DEF - 1) ? 0 : p + 1;
	endfunction

	function automatic kiss_result_t decode_item(kiss_req_t rq);
		kiss_result_t r;
		logic [7:0]   c;
		r = '0;
		c = rq.data;
		if (rq.op == OP_DEQUEUE) begin
			if (rd_ptr == wr_ptr) begin
				r.out_byte = IDLE_FLAG;
			end else begin
				r.out_byte = ring_copy[rd_ptr];
				rd_ptr = next_slot(rd_ptr);
			end
		end else if (c == FEND) begin
			cmd_armed = 1'b1;
		end else if (c == FESC) begin
			esc_armed = 1'b1;
		end else begin
			if (esc_armed) begin
				if (c == TFEND)
					c = FEND;
				else if (c == TFESC)
					c = FESC;
				esc_armed = 1'b0;
			end
			if (cmd_armed) begin
				sel = c[3:0] & SEL_MASK;
				cmd_armed = 1'b0;
			end else if (sel != SEL_DATA) begin
				// selectors past full duplex consume the value without storing it
				if (sel <= SEL_DUPLEX_MODE)
					params[int'(sel) - 1] = c;
				r.store = 1'b1;
				sel = SEL_DATA;
			end else begin
				ring_copy[wr_ptr] = c;
				wr_ptr = next_slot(wr_ptr);
			end
		end
		r.empty = (rd_ptr == wr_ptr);
		r.prm = params;
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
		n_errors++;
	endtask

	task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
		if (got !== want)
			report_mismatch(name, got, want);
	endtask

	function automatic int pick_odds();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 2;
			default: return 6;
		endcase
	endfunction

	// stimulus builders
	task automatic push_host(logic [7:0] b);
		kiss_req_t rq;
		rq.op = OP_HOST_BYTE;
		rq.data = b;
		host_requests.push_back(rq);
		host_count++;
	endtask

	task automatic push_deq();
		kiss_req_t rq;
		rq.op = OP_DEQUEUE;
		rq.data = 8'($urandom_range(0, 255));
		host_requests.push_back(rq);
	endtask

	task automatic push_escaped(logic [7:0] b);
		if (b == FEND) begin
			push_host(FESC);
			push_host(TFEND);
		end else if (b == FESC) begin
			push_host(FESC);
			push_host(TFESC);
		end else begin
			push_host(b);
		end
	endtask

	function automatic logic [7:0] biased_byte();
		case ($urandom_range(0, 9))
			0: return FEND;
			1: return FESC;
			2: return TFEND;
			3: return TFESC;
			4: return 8'h00;
			5: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic build_random();
		int pick;
		int len;
		logic [3:0] s;
		while (host_requests.size() < RANDOM_ITEMS + 25) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				push_host(FEND);
				push_escaped({4'($urandom_range(0, 15)), SEL_DATA});
				len = $urandom_range(1, 12);
				repeat (len) begin
					if ($urandom_range(0, 5) == 0)
						push_deq();
					push_escaped(biased_byte());
				end
				push_host(FEND);
			end else if (pick < 55) begin
				s = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) :
					4'($urandom_range(SEL_KEYUP_DELAY, SEL_DUPLEX_MODE));
				push_host(FEND);
				push_escaped({4'($urandom_range(0, 15)), s});
				push_escaped(biased_byte());
			end else if (pick < 85) begin
				repeat ($urandom_range(1, 6))
					push_deq();
			end else begin
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(0, 1) == 0)
						push_deq();
					else
						push_host(biased_byte());
				end
			end
		end
	endtask

	// driver
	kiss_req_t cur_req;
	int        gap_left;
	int        drv_odds;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			opcode <= 1'b0;
			host_byte <= 8'h00;
			gap_left = 0;
			drv_odds = 3;
		end else begin
			if (in_valid && !in_stall) begin
				pending_results.push_back(decode_item(cur_req));
				n_accepted++;
				if (n_accepted % 200 == 0)
					drv_odds = pick_odds();
			end
			// hold a stalled request as it is
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					in_valid <= 1'b0;
					gap_left--;
				end else if (host_requests.size() != 0) begin
					cur_req = host_requests.pop_front();
					in_valid <= 1'b1;
					opcode <= cur_req.op;
					host_byte <= cur_req.data;
					if (host_requests.size() > QUIET_TAIL && drv_odds != 0 &&
						$urandom_range(1, drv_odds) == 1)
						gap_left = $urandom_range(1, 4);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	int stall_left;
	int mon_odds;
	int mon_cycles;

	always @(posedge clk or negedge arst_n) begin
		kiss_result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
			mon_odds = 3;
			mon_cycles = 0;
		end else begin
			if (out_valid && !out_stall) begin
				n_results++;
				if (pending_results.size() == 0) begin
					report_mismatch("result with no request waiting", out_byte, 0);
				end else begin
					want = pending_results.pop_front();
					check_field("out_byte", out_byte, want.out_byte);
					check_field("ring_empty", ring_empty, want.empty);
					check_field("store_request", store_request, want.store);
					check_field("keyup_delay", keyup_delay, want.prm[0]);
					check_field("persistence", persistence, want.prm[1]);
					check_field("slot_period", slot_period, want.prm[2]);
					check_field("tx_tail", tx_tail, want.prm[3]);
					check_field("duplex_mode", duplex_mode, want.prm[4]);
				end
			end
			mon_cycles++;
			if (mon_cycles % 256 == 0)
				mon_odds = pick_odds();
			if (stall_left != 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else if (n_results + QUIET_TAIL < n_total && mon_odds != 0 &&
				$urandom_range(1, mon_odds) == 1) begin
				out_stall <= 1'b1;
				stall_left = $urandom_range(0, 3);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog: end the run when nothing moves for too long
	int idle_cycles;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		rd_ptr = 0;
		wr_ptr = 0;
		cmd_armed = 1'b0;
		esc_armed = 1'b0;
		sel = SEL_DATA;
		params = '0;

		// directed: empty dequeue, each escape rule, parameter writes, unused selector
		push_deq();
		push_host(FEND); push_host({4'h0, SEL_KEYUP_DELAY}); push_host(8'hFF);
		push_host(FEND); push_host({4'hF, SEL_SLOT_PERIOD}); push_host(FESC); push_host(TFEND);
		push_host(FEND); push_host({4'h0, SEL_TX_TAIL}); push_host(FESC); push_host(TFESC);
		push_host(FEND); push_host(8'h0A); push_host(8'h33);
		// escape stays armed across a delimiter; escaped command picks the data frame
		push_host(FESC); push_host(FEND); push_host(TFEND);
		push_host(8'h00);
		// doubled escape, then a plain byte passes through the escape
		push_host(FESC); push_host(FESC); push_host(8'h41);
		push_deq(); push_deq(); push_deq();

		build_random();

		// reset the decoder to the data frame, then empty the ring
		push_host(FEND);
		push_host({4'h0, SEL_DATA});
		repeat (host_count)
			push_deq();

		n_total = host_requests.size();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (host_requests.size() != 0 || in_valid)
			@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (n_errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
